FILE: rtl/bmcc_pkg.sv
// ----------------------------------------------------------------------------
// bmcc_pkg - blend mode channel combiner shared definitions
// Mode codes, pipeline control word and the overlay helper.
// ----------------------------------------------------------------------------
package bmcc_pkg;

	localparam int unsigned PixW = 8;
	localparam int unsigned ModeW = 5;
	localparam int unsigned DenW = 16;
	localparam int unsigned NumW = 24;
	localparam int unsigned ProdW = 16;

	localparam logic [PixW-1:0] PixMax = 8'd255;
	localparam logic [DenW-1:0] Den255 = 16'd255;
	localparam logic [DenW-1:0] Den255Sq = 16'd65025;

	typedef enum logic [ModeW-1:0] {
		BM_NORMAL     = 5'd0,
		BM_ADD        = 5'd1,
		BM_SUBTRACT   = 5'd2,
		BM_STAMP      = 5'd3,
		BM_DIFFERENCE = 5'd4,
		BM_NEGATION   = 5'd5,
		BM_MULTIPLY   = 5'd6,
		BM_DARKEN     = 5'd7,
		BM_LIGHTEN    = 5'd8,
		BM_DODGE      = 5'd9,
		BM_BURN       = 5'd10,
		BM_SCREEN     = 5'd11,
		BM_OVERLAY    = 5'd12,
		BM_HARDLIGHT  = 5'd13,
		BM_SOFTLIGHT  = 5'd14,
		BM_REFLECT    = 5'd15,
		BM_GLOW       = 5'd16,
		BM_FREEZE     = 5'd17,
		BM_HEAT       = 5'd18,
		BM_AND        = 5'd19,
		BM_OR         = 5'd20,
		BM_XOR        = 5'd21,
		BM_SHADOW     = 5'd22,
		BM_SYMOVL     = 5'd23
	} bm_mode_t;

	// result selection carried down the pipe with each word
	typedef struct packed {
		logic            is_div;
		logic            inv;
		logic            guard;
		logic            mul_b;
		logic [PixW-1:0] gval;
		logic [PixW-1:0] simple;
	} ctrl_t;

	typedef struct packed {
		ctrl_t            ctrl;
		logic [ProdW-1:0] num;
		logic [DenW-1:0]  den;
	} dec_t;

	// overlay from the two symmetric products a*b and (255-a)*(255-b)
	function automatic logic [PixW-1:0] ovl(input logic [PixW-1:0] x,
		input logic [ProdW-1:0] p_lo, input logic [ProdW-1:0] p_hi);
		logic [PixW-1:0] r;
		if (x[PixW-1]) begin
			r = PixMax - p_hi[14:7];
		end else begin
			r = p_lo[14:7];
		end
		return r;
	endfunction

endpackage

FILE: rtl/blend_mode_channel_combiner_top.sv
// ----------------------------------------------------------------------------
// blend_mode_channel_combiner_top - per-channel image blend pipeline
// Seven register stages: input, decode/products, numerator, four divide stages.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output is not stalled; set by the
// seven-stage pipeline, whose divider resolves two quotient bits per stage.
// Empty stages close up under output stall, so input keeps flowing into bubbles.
// Reset clears all stage valid bits and sets blend_mode to normal.
module blend_mode_channel_combiner_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bmcc_pkg::ModeW-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [bmcc_pkg::PixW-1:0]   base_value,
	input  logic [bmcc_pkg::PixW-1:0]   overlay_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bmcc_pkg::PixW-1:0]   blended_value
);
	import bmcc_pkg::*;

	logic [ModeW-1:0] blend_mode_q;
	logic [7:1]       v, en;

	logic [ModeW-1:0] mode_s1;
	logic [PixW-1:0]  a_s1, b_s1, b_s2;
	dec_t             dec, dec_s2;
	ctrl_t            ctrl_s3, ctrl_s4, ctrl_s5, ctrl_s6, ctrl_s7;
	logic [NumW-1:0]  num_s3, rem_s4, rem_s5, rem_s6, rem_s7;
	logic [DenW-1:0]  den_s3, den_s4, den_s5, den_s6, den_s7;
	logic             sat_s4, sat_s5, sat_s6, sat_s7;
	logic [PixW-1:0]  q_s4, q_s5, q_s6, q_s7;
	logic [NumW-1:0]  num3_c, rem4_c, rem5_c, rem6_c, rem7_c;
	logic [PixW-1:0]  q4_c, q5_c, q6_c, q7_c, qc, res;
	logic             sat3_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= BM_NORMAL;
		end else if (cfg_we) begin
			blend_mode_q <= cfg_wdata;
		end
	end

	// a stage moves when empty or when the one after it moves
	always_comb begin
		en[7] = !v[7] || !out_stall;
		for (int k = 6; k >= 1; k--) begin
			en[k] = !v[k] || en[k+1];
		end
	end
	assign in_stall = !en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1]) v[1] <= in_valid;
			for (int k = 2; k <= 7; k++) begin
				if (en[k]) v[k] <= v[k-1];
			end
		end
	end

	bmcc_decode u_decode (
		.mode (mode_s1),
		.a    (a_s1),
		.b    (b_s1),
		.dec  (dec)
	);

	always_comb begin
		num3_c = dec_s2.ctrl.mul_b ? NumW'(dec_s2.num) * NumW'(b_s2) : NumW'(dec_s2.num);
		sat3_c = num_s3 >= {den_s3, 8'd0};
	end

	bmcc_div_step2 u_div4 (.step_hi(3'd7), .rem_in(num_s3), .den(den_s3), .q_in('0),
		.rem_out(rem4_c), .q_out(q4_c));
	bmcc_div_step2 u_div5 (.step_hi(3'd5), .rem_in(rem_s4), .den(den_s4), .q_in(q_s4),
		.rem_out(rem5_c), .q_out(q5_c));
	bmcc_div_step2 u_div6 (.step_hi(3'd3), .rem_in(rem_s5), .den(den_s5), .q_in(q_s5),
		.rem_out(rem6_c), .q_out(q6_c));
	bmcc_div_step2 u_div7 (.step_hi(3'd1), .rem_in(rem_s6), .den(den_s6), .q_in(q_s6),
		.rem_out(rem7_c), .q_out(q7_c));

	always_comb begin
		qc = sat_s6 ? PixMax : q7_c;
		if (!ctrl_s6.is_div) res = ctrl_s6.simple;
		else if (ctrl_s6.guard) res = ctrl_s6.gval;
		else if (ctrl_s6.inv) res = PixMax - qc;
		else res = qc;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mode_s1 <= blend_mode_q;
			a_s1 <= base_value;
			b_s1 <= overlay_value;
		end
		if (en[2]) begin
			dec_s2 <= dec;
			b_s2 <= b_s1;
		end
		if (en[3]) begin
			ctrl_s3 <= dec_s2.ctrl;
			num_s3 <= num3_c;
			den_s3 <= dec_s2.den;
		end
		if (en[4]) begin
			ctrl_s4 <= ctrl_s3;
			den_s4 <= den_s3;
			sat_s4 <= sat3_c;
			rem_s4 <= rem4_c;
			q_s4 <= q4_c;
		end
		if (en[5]) begin
			ctrl_s5 <= ctrl_s4;
			den_s5 <= den_s4;
			sat_s5 <= sat_s4;
			rem_s5 <= rem5_c;
			q_s5 <= q5_c;
		end
		if (en[6]) begin
			ctrl_s6 <= ctrl_s5;
			den_s6 <= den_s5;
			sat_s6 <= sat_s5;
			rem_s6 <= rem6_c;
			q_s6 <= q6_c;
		end
		if (en[7]) begin
			ctrl_s7 <= ctrl_s6;
			den_s7 <= den_s6;
			sat_s7 <= sat_s6;
			rem_s7 <= rem7_c;
			q_s7 <= res;
		end
	end

	assign out_valid = v[7];
	assign blended_value = q_s7;

	// input only backs up when the whole pipe is full and the output is held
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && (&v)))
		else $error("input stalled with room in pipe");

	// no quotient overflow past the first divide stage
	a_rem_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(v[4] && ctrl_s4.is_div && !sat_s4) |-> (rem_s4 < (NumW'(den_s4) << 6)))
		else $error("divide remainder out of range at stage 4");

	// final remainder below divisor
	a_rem_s7: assert property (@(posedge clk) disable iff (!arst_n)
		(v[7] && ctrl_s7.is_div && !sat_s7) |-> (rem_s7 < NumW'(den_s7)))
		else $error("divide remainder out of range at output");

	// a zero divisor only reaches the output under a guard or saturation
	a_den_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v[7] && ctrl_s7.is_div && den_s7 == '0) |-> (ctrl_s7.guard || sat_s7))
		else $error("unguarded zero divisor");

endmodule

FILE: rtl/bmcc_decode.sv
// ----------------------------------------------------------------------------
// bmcc_decode - mode decode and first products
// Computes the direct modes and sets up numerator and divisor for the rest.
// ----------------------------------------------------------------------------
module bmcc_decode (
	input  logic [bmcc_pkg::ModeW-1:0] mode,
	input  logic [bmcc_pkg::PixW-1:0]  a,
	input  logic [bmcc_pkg::PixW-1:0]  b,
	output bmcc_pkg::dec_t             dec
);
	import bmcc_pkg::*;

	logic [PixW-1:0]  na, nb, sq_op, o_ab, o_ba;
	logic [ProdW-1:0] p_lo, p_hi, p_sq;
	logic [PixW:0]    sum, stamp_t, b2, stamp_d, sym;

	always_comb begin
		na = PixMax - a;
		nb = PixMax - b;
		case (bm_mode_t'(mode))
			BM_GLOW:    sq_op = b;
			BM_FREEZE:  sq_op = na;
			BM_HEAT:    sq_op = nb;
			default:    sq_op = a;
		endcase
		p_lo = ProdW'(a) * ProdW'(b);
		p_hi = ProdW'(na) * ProdW'(nb);
		p_sq = ProdW'(sq_op) * ProdW'(sq_op);
		o_ab = ovl(a, p_lo, p_hi);
		o_ba = ovl(b, p_lo, p_hi);
		sum = {1'b0, a} + {1'b0, b};
		stamp_t = {1'b1, a};
		b2 = {b, 1'b0};
		stamp_d = stamp_t - b2;
		sym = {1'b0, o_ab} + {1'b0, o_ba};

		dec = '0;
		dec.den = Den255;
		case (bm_mode_t'(mode))
			BM_NORMAL, BM_SOFTLIGHT: dec.ctrl.simple = b;
			BM_ADD:        dec.ctrl.simple = sum[PixW] ? PixMax : sum[PixW-1:0];
			BM_SUBTRACT:   dec.ctrl.simple = (a > b) ? a - b : '0;
			BM_STAMP: begin
				if (stamp_t <= b2) dec.ctrl.simple = '0;
				else dec.ctrl.simple = stamp_d[PixW] ? PixMax : stamp_d[PixW-1:0];
			end
			BM_DIFFERENCE: dec.ctrl.simple = (a > b) ? a - b : b - a;
			BM_NEGATION: begin
				if (sum > 9'd255) dec.ctrl.simple = PixW'(9'd510 - sum);
				else dec.ctrl.simple = sum[PixW-1:0];
			end
			BM_DARKEN:     dec.ctrl.simple = (a < b) ? a : b;
			BM_LIGHTEN:    dec.ctrl.simple = (a > b) ? a : b;
			BM_OVERLAY:    dec.ctrl.simple = o_ab;
			BM_HARDLIGHT:  dec.ctrl.simple = o_ba;
			BM_AND:        dec.ctrl.simple = a & b;
			BM_OR:         dec.ctrl.simple = a | b;
			BM_XOR:        dec.ctrl.simple = a ^ b;
			BM_SYMOVL:     dec.ctrl.simple = sym[PixW:1];
			BM_MULTIPLY: begin
				dec.ctrl.is_div = 1'b1;
				dec.num = p_lo;
			end
			BM_SCREEN: begin
				dec.ctrl.is_div = 1'b1;
				dec.ctrl.inv = 1'b1;
				dec.num = p_hi;
			end
			BM_DODGE: begin
				dec.ctrl.is_div = 1'b1;
				dec.ctrl.guard = (b == PixMax);
				dec.ctrl.gval = PixMax;
				dec.num = {a, 8'd0} - ProdW'(a);
				dec.den = DenW'(nb);
			end
			BM_BURN: begin
				dec.ctrl.is_div = 1'b1;
				dec.ctrl.inv = 1'b1;
				dec.ctrl.guard = (b == '0);
				dec.num = {na, 8'd0} - ProdW'(na);
				dec.den = DenW'(b);
			end
			BM_REFLECT: begin
				dec.ctrl.is_div = 1'b1;
				dec.ctrl.guard = (b == PixMax);
				dec.ctrl.gval = PixMax;
				dec.num = p_sq;
				dec.den = DenW'(nb);
			end
			BM_GLOW: begin
				dec.ctrl.is_div = 1'b1;
				dec.ctrl.guard = (a == PixMax);
				dec.ctrl.gval = PixMax;
				dec.num = p_sq;
				dec.den = DenW'(na);
			end
			BM_FREEZE: begin
				dec.ctrl.is_div = 1'b1;
				dec.ctrl.inv = 1'b1;
				dec.ctrl.guard = (b == '0);
				dec.num = p_sq;
				dec.den = DenW'(b);
			end
			BM_HEAT: begin
				dec.ctrl.is_div = 1'b1;
				dec.ctrl.inv = 1'b1;
				dec.ctrl.guard = (a == '0);
				dec.num = p_sq;
				dec.den = DenW'(a);
			end
			BM_SHADOW: begin
				dec.ctrl.is_div = 1'b1;
				dec.ctrl.mul_b = 1'b1;
				dec.num = p_sq;
				dec.den = Den255Sq;
			end
			default:       dec.ctrl.simple = a;
		endcase
	end

endmodule

FILE: rtl/bmcc_div_step2.sv
// ----------------------------------------------------------------------------
// bmcc_div_step2 - two restoring division steps
// Develops quotient bits hi and hi-1 of a quotient known to be below 256.
// ----------------------------------------------------------------------------
module bmcc_div_step2 (
	input  logic [2:0]                 step_hi,
	input  logic [bmcc_pkg::NumW-1:0]  rem_in,
	input  logic [bmcc_pkg::DenW-1:0]  den,
	input  logic [bmcc_pkg::PixW-1:0]  q_in,
	output logic [bmcc_pkg::NumW-1:0]  rem_out,
	output logic [bmcc_pkg::PixW-1:0]  q_out
);
	import bmcc_pkg::*;

	logic [NumW-1:0] d_hi, d_lo, rem_mid;
	logic [2:0]      step_lo;
	logic [PixW-1:0] q_mid;

	always_comb begin
		step_lo = step_hi - 3'd1;
		d_hi = NumW'(den) << step_hi;
		d_lo = NumW'(den) << step_lo;
		rem_mid = rem_in;
		q_mid = q_in;
		if (rem_in >= d_hi) begin
			rem_mid = rem_in - d_hi;
			q_mid[step_hi] = 1'b1;
		end
		rem_out = rem_mid;
		q_out = q_mid;
		if (rem_mid >= d_lo) begin
			rem_out = rem_mid - d_lo;
			q_out[step_lo] = 1'b1;
		end
	end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb - blend mode channel combiner testbench
// Directed table plus random words across all mode settings, with random
// gaps and output stall; each output word is checked against a local predictor.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bmcc_pkg::*;

	localparam int Latency = 7;
	localparam int NoCheck = -1;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ModeW-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic [PixW-1:0] base_value;
	logic [PixW-1:0] overlay_value;
	logic out_valid;
	logic out_stall;
	logic [PixW-1:0] blended_value;

	logic [ModeW-1:0] mode_q;
	logic [PixW-1:0] blend_q[$];
	int errors;

	typedef struct {
		logic [ModeW-1:0] mode;
		logic [PixW-1:0] a;
		logic [PixW-1:0] b;
		int want;
	} row_t;

	blend_mode_channel_combiner_top uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .base_value(base_value),
		.overlay_value(overlay_value), .out_valid(out_valid),
		.out_stall(out_stall), .blended_value(blended_value)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned ovl_byte(int unsigned a, int unsigned b);
		if (a < 128)
			return (a * b) >> 7;
		return 255 - (((255 - a) * (255 - b)) >> 7);
	endfunction

	function automatic int unsigned sat(int unsigned v);
		return v > 255 ? 255 : v;
	endfunction

	function automatic int unsigned floor_sub(int unsigned s);
		return s >= 255 ? 0 : 255 - s;
	endfunction

	function automatic logic [PixW-1:0] blend_byte(logic [ModeW-1:0] m,
		logic [PixW-1:0] ba, logic [PixW-1:0] bb);
		int unsigned a;
		int unsigned b;
		int unsigned t;
		int unsigned r;
		a = ba;
		b = bb;
		case (m)
			BM_NORMAL, BM_SOFTLIGHT: r = b;
			BM_ADD: r = sat(a + b);
			BM_SUBTRACT: r = a > b ? a - b : 0;
			BM_STAMP: begin
				t = a + 256;
				r = t <= 2 * b ? 0 : sat(t - 2 * b);
			end
			BM_DIFFERENCE: r = a > b ? a - b : b - a;
			BM_NEGATION: begin
				t = a + b;
				r = t > 255 ? 510 - t : t;
			end
			BM_MULTIPLY: r = (a * b) / 255;
			BM_DARKEN: r = a < b ? a : b;
			BM_LIGHTEN: r = a > b ? a : b;
			BM_DODGE: r = b == 255 ? 255 : sat((a * 255) / (255 - b));
			BM_BURN: r = b == 0 ? 0 : floor_sub(((255 - a) * 255) / b);
			BM_SCREEN: r = 255 - ((255 - a) * (255 - b)) / 255;
			BM_OVERLAY: r = ovl_byte(a, b);
			BM_HARDLIGHT: r = ovl_byte(b, a);
			BM_REFLECT: r = b == 255 ? 255 : sat((a * a) / (255 - b));
			BM_GLOW: r = a == 255 ? 255 : sat((b * b) / (255 - a));
			BM_FREEZE: r = b == 0 ? 0 : floor_sub(((255 - a) * (255 - a)) / b);
			BM_HEAT: r = a == 0 ? 0 : floor_sub(((255 - b) * (255 - b)) / a);
			BM_AND: r = a & b;
			BM_OR: r = a | b;
			BM_XOR: r = a ^ b;
			BM_SHADOW: r = (b * a * a) / 65025;
			BM_SYMOVL: r = (ovl_byte(a, b) + ovl_byte(b, a)) / 2;
			default: r = a;
		endcase
		return r[PixW-1:0];
	endfunction

	// wait until every expected word is back, then let the pipe drain
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (blend_q.size() != 0)
			@(negedge clk);
		repeat (Latency + 2) @(negedge clk);
	endtask

	task automatic set_mode(logic [ModeW-1:0] m);
		drain_pipe();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		mode_q = m;
	endtask

	// valid stays high into the next word when no gap is drawn
	task automatic send_word(logic [PixW-1:0] a, logic [PixW-1:0] b, int want);
		logic [PixW-1:0] p;
		int idle;
		idle = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		p = blend_byte(mode_q, a, b);
		if (want != NoCheck && p !== want[PixW-1:0]) begin
			$error("table blended_value: expected %0d, actual %0d", want, p);
			errors++;
		end
		in_valid <= 1'b1;
		base_value <= a;
		overlay_value <= b;
		blend_q.push_back(p);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// output side: random stall, check at rising edge
	initial begin
		int hold;
		out_stall = 1'b1;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 4) == 0) begin
				hold = $urandom_range(0, 18);
				if (hold > 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(negedge clk);
				end
			end
			out_stall <= 1'b0;
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (blend_q.size() == 0) begin
					$error("blended_value: unexpected word %0d", blended_value);
					errors++;
				end else begin
					if (blended_value !== blend_q[0]) begin
						$error("blended_value: expected %0d, actual %0d",
							blend_q[0], blended_value);
						errors++;
					end
					void'(blend_q.pop_front());
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		row_t dir[$];
		int m;
		logic [PixW-1:0] a;
		logic [PixW-1:0] b;
		errors = 0;
		mode_q = BM_NORMAL;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		base_value = '0;
		overlay_value = '0;
		dir = '{
			'{BM_NORMAL, 8'd12, 8'd200, 200},
			'{BM_ADD, 8'd255, 8'd255, 255},
			'{BM_SUBTRACT, 8'd0, 8'd255, 0},
			'{BM_STAMP, 8'd0, 8'd255, 0},
			'{BM_STAMP, 8'd255, 8'd0, 255},
			'{BM_DIFFERENCE, 8'd0, 8'd255, 255},
			'{BM_NEGATION, 8'd255, 8'd255, 0},
			'{BM_MULTIPLY, 8'd255, 8'd255, 255},
			'{BM_DARKEN, 8'd17, 8'd90, 17},
			'{BM_LIGHTEN, 8'd17, 8'd90, 90},
			'{BM_DODGE, 8'd0, 8'd255, 255},
			'{BM_BURN, 8'd255, 8'd0, 0},
			'{BM_SCREEN, 8'd0, 8'd0, 0},
			'{BM_OVERLAY, 8'd127, 8'd255, NoCheck},
			'{BM_HARDLIGHT, 8'd255, 8'd128, NoCheck},
			'{BM_SOFTLIGHT, 8'd3, 8'd77, 77},
			'{BM_REFLECT, 8'd255, 8'd254, 255},
			'{BM_GLOW, 8'd255, 8'd0, 255},
			'{BM_FREEZE, 8'd0, 8'd0, 0},
			'{BM_HEAT, 8'd0, 8'd255, 0},
			'{BM_AND, 8'hF0, 8'h3C, 8'h30},
			'{BM_OR, 8'hF0, 8'h3C, 8'hFC},
			'{BM_XOR, 8'hFF, 8'h55, 8'hAA},
			'{BM_SHADOW, 8'd255, 8'd255, 255},
			'{BM_SYMOVL, 8'd128, 8'd127, NoCheck},
			'{5'd31, 8'd99, 8'd1, 99}
		};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_word(8'd44, 8'd55, 55); // normal after reset
		foreach (dir[i]) begin
			if (dir[i].mode != mode_q)
				set_mode(dir[i].mode);
			send_word(dir[i].a, dir[i].b, dir[i].want);
		end
		for (int ph = 0; ph < 32; ph++) begin
			set_mode(ph[ModeW-1:0]);
			for (int k = 0; k < 60; k++) begin
				m = $urandom_range(0, 9);
				a = PixW'($urandom_range(0, 255));
				b = PixW'($urandom_range(0, 255));
				if (m == 0) a = 8'd0;
				if (m == 1) a = 8'd255;
				if (m == 2) b = 8'd0;
				if (m == 3) b = 8'd255;
				send_word(a, b, NoCheck);
			end
			if (ph == 10)
				drain_pipe();
		end
		drain_pipe();
		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end
endmodule

FILE: files.f
rtl/bmcc_pkg.sv
rtl/bmcc_decode.sv
rtl/bmcc_div_step2.sv
rtl/blend_mode_channel_combiner_top.sv
dv/tb.sv
